[hdl/ppt_pkg.sv]
// Package for the planar pose transform: field widths, CORDIC constants,
// the arctangent table and the types used by the top level and the rotator.
// Depends on nothing.
package ppt_pkg;

  // Field widths of the transaction.
  localparam int POS_WIDTH     = 20;
  localparam int ANGLE_WIDTH   = 16;
  localparam int CORDIC_STAGES = 16;

  // Arctangent table length, and the number of micro-rotations really built.
  localparam int ATAN_LEN = 24;
  localparam int NSTG     = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

  // Fixed-point format: the gain-compensated scale is Q28.
  localparam int FRAC_BITS   = 28;
  localparam int KGAIN_WIDTH = 29;
  localparam logic signed [KGAIN_WIDTH-1:0] KGAIN = 29'sd163008219;

  // Internal widths.
  localparam int VEC_WIDTH  = POS_WIDTH + 1;               // difference of two positions
  localparam int FOLD_WIDTH = POS_WIDTH + 2;               // after quadrant negation
  localparam int CW         = FOLD_WIDTH + KGAIN_WIDTH + 1; // CORDIC datapath
  localparam int ZW         = 33;                          // residual angle, 2^32 per turn
  localparam int RW         = POS_WIDTH + 3;               // rounded rotator output
  localparam int SW         = POS_WIDTH + 4;               // sum before clipping

  // atan(2^-i) at 2^32 per turn.
  localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic [1:0] {
    KIND_WORLD     = 2'd0,
    KIND_ROBOT     = 2'd1,
    KIND_WALK      = 2'd2,
    KIND_WORLD_ALT = 2'd3
  } kind_e;

  // Data that rides alongside the rotation: result heading and the offset
  // added to the rotated vector.
  typedef struct packed {
    logic        [ANGLE_WIDTH-1:0] heading;
    logic signed [POS_WIDTH-1:0]   add_x;
    logic signed [POS_WIDTH-1:0]   add_y;
  } side_t;

endpackage

[hdl/ppt_cordic.sv]
// Pipelined gain-compensated CORDIC rotator with its own valid/ready flow
// control: quadrant fold, gain multiply, one micro-rotation per stage, rounding.
// Depends on ppt_pkg.
module ppt_cordic (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic signed [ppt_pkg::VEC_WIDTH-1:0]    in_x_i,
  input  logic signed [ppt_pkg::VEC_WIDTH-1:0]    in_y_i,
  input  logic        [ppt_pkg::ANGLE_WIDTH-1:0]  in_angle_i,
  input  ppt_pkg::side_t                          in_side_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [ppt_pkg::RW-1:0]           out_x_o,
  output logic signed [ppt_pkg::RW-1:0]           out_y_o,
  output ppt_pkg::side_t                          out_side_o
);

  localparam int NS   = ppt_pkg::NSTG;
  localparam int LAST = NS + 2;
  localparam int FW   = ppt_pkg::FOLD_WIDTH;
  localparam int KW   = ppt_pkg::KGAIN_WIDTH;
  localparam int CW   = ppt_pkg::CW;
  localparam int ZW   = ppt_pkg::ZW;
  localparam int RW   = ppt_pkg::RW;
  localparam int AW   = ppt_pkg::ANGLE_WIDTH;
  localparam int FB   = ppt_pkg::FRAC_BITS;
  localparam logic signed [CW-1:0] HALF = CW'(1) << (FB - 1);

  // Stage 0 is the fold, stage 1 the multiply, stages 2..NS+1 the
  // micro-rotations and stage LAST the rounding register.
  logic [LAST:0]   v_q;
  logic [LAST+1:0] rdy;
  logic [LAST:0]   pv;

  assign rdy[LAST+1] = out_ready_i;
  assign pv          = {v_q[LAST-1:0], in_valid_i};

  for (genvar k = 0; k <= LAST; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k <= LAST; k++) begin
        if (rdy[k]) begin
          v_q[k] <= pv[k];
        end
      end
    end
  end

  ppt_pkg::side_t side_q [LAST+1];

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      side_q[0] <= in_side_i;
    end
    for (int k = 1; k <= LAST; k++) begin
      if (rdy[k] && v_q[k-1]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Quadrant fold: angles in the second or third quadrant take a half turn
  // and a negated vector, leaving the residual within a quarter turn.
  logic                   quad_flip;
  logic signed [FW-1:0]   x_ext, y_ext, fold_x_d, fold_y_d;
  logic signed [FW-1:0]   fold_x_q, fold_y_q;
  logic        [AW-1:0]   ang_f;
  logic signed [ZW-1:0]   z0_d, z0_q;

  assign quad_flip = in_angle_i[AW-1] ^ in_angle_i[AW-2];
  assign x_ext     = FW'(in_x_i);
  assign y_ext     = FW'(in_y_i);
  assign fold_x_d  = quad_flip ? -x_ext : x_ext;
  assign fold_y_d  = quad_flip ? -y_ext : y_ext;
  assign ang_f     = {in_angle_i[AW-1] ^ quad_flip, in_angle_i[AW-2:0]};
  assign z0_d      = {ang_f[AW-1], ang_f, {(32 - AW){1'b0}}};

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      fold_x_q <= fold_x_d;
      fold_y_q <= fold_y_d;
      z0_q     <= z0_d;
    end
  end

  // Gain compensation by multiplying with round(K * 2^28).
  logic signed [FW+KW-1:0] prod_x, prod_y;
  logic signed [CW-1:0]    x_q [NS+1];
  logic signed [CW-1:0]    y_q [NS+1];
  logic signed [ZW-1:0]    z_q [NS+1];

  assign prod_x = fold_x_q * ppt_pkg::KGAIN;
  assign prod_y = fold_y_q * ppt_pkg::KGAIN;

  always_ff @(posedge clk_i) begin
    if (rdy[1] && v_q[0]) begin
      x_q[0] <= CW'(prod_x);
      y_q[0] <= CW'(prod_y);
      z_q[0] <= z0_q;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_iter
    logic signed [CW-1:0] sx, sy;
    logic signed [ZW-1:0] tab;
    logic                 pos;

    assign sx  = y_q[i] >>> i;
    assign sy  = x_q[i] >>> i;
    assign tab = {1'b0, ppt_pkg::ATAN_TAB[i]};
    assign pos = !z_q[i][ZW-1];

    always_ff @(posedge clk_i) begin
      if (rdy[i+2] && v_q[i+1]) begin
        x_q[i+1] <= pos ? (x_q[i] - sx) : (x_q[i] + sx);
        y_q[i+1] <= pos ? (y_q[i] + sy) : (y_q[i] - sy);
        z_q[i+1] <= pos ? (z_q[i] - tab) : (z_q[i] + tab);
      end
    end
  end

  // Round to nearest, ties toward plus infinity.
  logic signed [CW-1:0] rnd_x, rnd_y;
  logic signed [RW-1:0] rx_q, ry_q;

  assign rnd_x = x_q[NS] + HALF;
  assign rnd_y = y_q[NS] + HALF;

  always_ff @(posedge clk_i) begin
    if (rdy[LAST] && v_q[LAST-1]) begin
      rx_q <= rnd_x[FB+RW-1:FB];
      ry_q <= rnd_y[FB+RW-1:FB];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[LAST];
  assign out_x_o     = rx_q;
  assign out_y_o     = ry_q;
  assign out_side_o  = side_q[LAST];

  // The pipeline refuses a transaction only when every stage is occupied.
  a_full_when_refusing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&v_q))
    else $error("rotator stalls its input while holding a bubble");

  // After the fold the residual angle lies within a quarter turn.
  a_fold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] |-> (z0_q[ZW-1] == z0_q[ZW-2]) && (z0_q[ZW-2] == z0_q[ZW-3]))
    else $error("folded angle outside a quarter turn");

  // A stalled result stays in the rounding register.
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_x_o) && $stable(out_y_o))
    else $error("rotator result changed while stalled");

endmodule

[hdl/planar_pose_transform.sv]
// Top level of the planar pose transform: mode decode, the CORDIC rotator and
// the offset, clipping and output register stage.
// Depends on ppt_pkg and ppt_cordic.

// The block transforms one planar pose (x, y, heading) against a reference
// pose in every clock cycle and keeps no state between transactions. Kind 0
// (and kind 3) rotates the item position by the frame heading and adds the
// frame position; kind 1 subtracts the frame position and rotates by the
// negated frame heading; in both the item heading passes through unchanged.
// Kind 2 walks: the new heading is the wrapped sum of both headings and the
// frame position, rotated by it, is added to the item position. Positions
// are signed millimetres, headings binary angles of 65536 per turn. Rotation
// is a gain-compensated CORDIC rounded to the nearest millimetre, and a
// position that leaves its range is clipped and raises the saturated flag.
// One transaction is accepted per cycle at full rate while the output takes
// results; each passes through 21 register stages (one decode stage, the
// fold, the gain multiply, sixteen micro-rotation stages, rounding and the
// output register) in that order. A stall at the output only halts the
// pipeline once every stage is occupied, so empty stages are squeezed out
// first.
module planar_pose_transform (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic        [1:0]                      kind_i,
  input  logic signed [ppt_pkg::POS_WIDTH-1:0]   item_x_i,
  input  logic signed [ppt_pkg::POS_WIDTH-1:0]   item_y_i,
  input  logic signed [ppt_pkg::ANGLE_WIDTH-1:0] item_heading_i,
  input  logic signed [ppt_pkg::POS_WIDTH-1:0]   frame_x_i,
  input  logic signed [ppt_pkg::POS_WIDTH-1:0]   frame_y_i,
  input  logic signed [ppt_pkg::ANGLE_WIDTH-1:0] frame_heading_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [ppt_pkg::POS_WIDTH-1:0]   out_x_o,
  output logic signed [ppt_pkg::POS_WIDTH-1:0]   out_y_o,
  output logic signed [ppt_pkg::ANGLE_WIDTH-1:0] out_heading_o,
  output logic                                   saturated_o
);

  localparam int PW = ppt_pkg::POS_WIDTH;
  localparam int AW = ppt_pkg::ANGLE_WIDTH;
  localparam int VW = ppt_pkg::VEC_WIDTH;
  localparam int RW = ppt_pkg::RW;
  localparam int SW = ppt_pkg::SW;
  localparam logic signed [SW-1:0] POS_HI = SW'((64'sd1 <<< (PW - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] POS_LO = -POS_HI - SW'(1);

  // Decode stage. The vector to rotate, its angle and the side data are
  // chosen by kind; the robot-frame difference is formed here so that the
  // rotator sees the same shape of work in every mode.
  logic signed [VW-1:0] vec_x_d, vec_y_d;
  logic        [AW-1:0] ang_d;
  ppt_pkg::side_t       side_d;
  logic        [AW-1:0] head_sum;

  assign head_sum = item_heading_i + frame_heading_i;

  always_comb begin
    unique case (ppt_pkg::kind_e'(kind_i))
      ppt_pkg::KIND_ROBOT: begin
        vec_x_d       = VW'(item_x_i) - VW'(frame_x_i);
        vec_y_d       = VW'(item_y_i) - VW'(frame_y_i);
        ang_d         = -frame_heading_i;
        side_d.heading = item_heading_i;
        side_d.add_x  = '0;
        side_d.add_y  = '0;
      end
      ppt_pkg::KIND_WALK: begin
        vec_x_d       = VW'(frame_x_i);
        vec_y_d       = VW'(frame_y_i);
        ang_d         = head_sum;
        side_d.heading = head_sum;
        side_d.add_x  = item_x_i;
        side_d.add_y  = item_y_i;
      end
      ppt_pkg::KIND_WORLD, ppt_pkg::KIND_WORLD_ALT: begin
        vec_x_d       = VW'(item_x_i);
        vec_y_d       = VW'(item_y_i);
        ang_d         = frame_heading_i;
        side_d.heading = item_heading_i;
        side_d.add_x  = frame_x_i;
        side_d.add_y  = frame_y_i;
      end
      default: begin
        vec_x_d       = '0;
        vec_y_d       = '0;
        ang_d         = '0;
        side_d        = '0;
      end
    endcase
  end

  logic                 a_v_q;
  logic signed [VW-1:0] a_x_q, a_y_q;
  logic        [AW-1:0] a_ang_q;
  ppt_pkg::side_t       a_side_q;
  logic                 rot_ready;

  assign in_ready_o = !a_v_q || rot_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (in_ready_o) begin
      a_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      a_x_q    <= vec_x_d;
      a_y_q    <= vec_y_d;
      a_ang_q  <= ang_d;
      a_side_q <= side_d;
    end
  end

  // Rotator.
  logic                 rot_valid;
  logic                 rot_take;
  logic signed [RW-1:0] rot_x, rot_y;
  ppt_pkg::side_t       rot_side;

  ppt_cordic u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (a_v_q),
    .in_ready_o  (rot_ready),
    .in_x_i      (a_x_q),
    .in_y_i      (a_y_q),
    .in_angle_i  (a_ang_q),
    .in_side_i   (a_side_q),
    .out_valid_o (rot_valid),
    .out_ready_i (rot_take),
    .out_x_o     (rot_x),
    .out_y_o     (rot_y),
    .out_side_o  (rot_side)
  );

  // Offset, clip and output register. The output register parts the two
  // sides, so the rotator keeps moving while a result waits here as long as
  // it has a free stage.
  logic signed [SW-1:0] sum_x, sum_y;
  logic signed [PW-1:0] clip_x, clip_y;
  logic                 sat_x, sat_y;
  logic                 o_v_q;
  logic signed [PW-1:0] o_x_q, o_y_q;
  logic        [AW-1:0] o_h_q;
  logic                 o_sat_q;

  assign sum_x = SW'(rot_x) + SW'(rot_side.add_x);
  assign sum_y = SW'(rot_y) + SW'(rot_side.add_y);

  always_comb begin
    sat_x = 1'b1;
    if (sum_x > POS_HI) begin
      clip_x = POS_HI[PW-1:0];
    end else if (sum_x < POS_LO) begin
      clip_x = POS_LO[PW-1:0];
    end else begin
      clip_x = sum_x[PW-1:0];
      sat_x  = 1'b0;
    end
    sat_y = 1'b1;
    if (sum_y > POS_HI) begin
      clip_y = POS_HI[PW-1:0];
    end else if (sum_y < POS_LO) begin
      clip_y = POS_LO[PW-1:0];
    end else begin
      clip_y = sum_y[PW-1:0];
      sat_y  = 1'b0;
    end
  end

  assign rot_take = !o_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (rot_take) begin
      o_v_q <= rot_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rot_take && rot_valid) begin
      o_x_q   <= clip_x;
      o_y_q   <= clip_y;
      o_h_q   <= rot_side.heading;
      o_sat_q <= sat_x || sat_y;
    end
  end

  assign out_valid_o   = o_v_q;
  assign out_x_o       = o_x_q;
  assign out_y_o       = o_y_q;
  assign out_heading_o = o_h_q;
  assign saturated_o   = o_sat_q;

  // A saturated result has at least one coordinate at a range limit.
  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      (out_x_o == POS_HI[PW-1:0]) || (out_x_o == POS_LO[PW-1:0]) ||
      (out_y_o == POS_HI[PW-1:0]) || (out_y_o == POS_LO[PW-1:0]))
    else $error("saturated flag without a clipped coordinate");

  // The decode stage refuses a transaction only while it holds one.
  a_refuse_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> a_v_q)
    else $error("decode stage stalls while empty");

  // An accepted transaction always lands in the decode stage.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> a_v_q)
    else $error("accepted transaction lost in decode stage");

endmodule
